// ----- design/llpm_pkg.sv -----
// ----------------------------------------------------------------------------
// llpm_pkg
// shared types, codes and sizes of the linked list pool manager
// ----------------------------------------------------------------------------
package llpm_pkg;

	// pool and list sizes
	localparam int NODE_COUNT = 256;
	localparam int NODE_AW    = $clog2(NODE_COUNT);
	localparam int NODE_W     = NODE_AW + 1;
	localparam int LIST_AW    = 4;
	localparam int LIST_COUNT = 1 << LIST_AW;
	localparam int LIST_W     = LIST_AW + 1;
	localparam int ITEM_WIDTH = 32;
	localparam int COUNT_W    = NODE_W;

	typedef logic [NODE_W-1:0]     node_ptr_t;
	typedef logic [NODE_AW-1:0]    node_addr_t;
	typedef logic [LIST_W-1:0]     list_ptr_t;
	typedef logic [LIST_AW-1:0]    list_idx_t;
	typedef logic [ITEM_WIDTH-1:0] item_t;
	typedef logic [COUNT_W-1:0]    count_t;

	localparam node_ptr_t NIL_NODE = node_ptr_t'(NODE_COUNT);
	localparam list_ptr_t NIL_LIST = list_ptr_t'(LIST_COUNT);

	// operation codes
	localparam logic [3:0] OP_CREATE  = 4'd0;
	localparam logic [3:0] OP_COUNT   = 4'd1;
	localparam logic [3:0] OP_FIRST   = 4'd2;
	localparam logic [3:0] OP_LAST    = 4'd3;
	localparam logic [3:0] OP_NEXT    = 4'd4;
	localparam logic [3:0] OP_PREV    = 4'd5;
	localparam logic [3:0] OP_CURRENT = 4'd6;
	localparam logic [3:0] OP_ADD     = 4'd7;
	localparam logic [3:0] OP_INSERT  = 4'd8;
	localparam logic [3:0] OP_APPEND  = 4'd9;
	localparam logic [3:0] OP_PREPEND = 4'd10;
	localparam logic [3:0] OP_REMOVE  = 4'd11;
	localparam logic [3:0] OP_TRIM    = 4'd12;
	localparam logic [3:0] OP_CONCAT  = 4'd13;
	localparam logic [3:0] OP_FREE    = 4'd14;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_ITEM   = 2'd1;
	localparam logic [1:0] ST_EXHAUSTED = 2'd2;
	localparam logic [1:0] ST_UNUSED    = 2'd3;

	// cursor side marker
	localparam logic [1:0] SIDE_ON     = 2'd0;
	localparam logic [1:0] SIDE_BEFORE = 2'd1;
	localparam logic [1:0] SIDE_BEYOND = 2'd2;

	// one list descriptor as kept in the list table
	typedef struct packed {
		node_ptr_t  head;
		node_ptr_t  tail;
		node_ptr_t  cursor;
		count_t     len;
		logic [1:0] side;
	} list_entry_t;

	// node memory read request
	typedef struct packed {
		logic       nxt_en;
		node_addr_t nxt_addr;
		logic       prv_en;
		node_addr_t prv_addr;
		logic       val_en;
		node_addr_t val_addr;
	} node_rd_t;

	// node memory write request
	typedef struct packed {
		logic       nxt_we;
		node_addr_t nxt_addr;
		node_ptr_t  nxt_data;
		logic       prv_we;
		node_addr_t prv_addr;
		node_ptr_t  prv_data;
		logic       val_we;
		node_addr_t val_addr;
		item_t      val_data;
	} node_wr_t;

	// node memory read data
	typedef struct packed {
		node_ptr_t nxt;
		node_ptr_t prv;
		item_t     val;
	} node_rdata_t;

	function automatic list_entry_t empty_list();
		list_entry_t e;
		e.head   = NIL_NODE;
		e.tail   = NIL_NODE;
		e.cursor = NIL_NODE;
		e.len    = '0;
		e.side   = SIDE_BEFORE;
		return e;
	endfunction

	function automatic node_addr_t node_addr(input node_ptr_t p);
		return p[NODE_AW-1:0];
	endfunction

endpackage

// ----- design/llpm_node_pool.sv -----
// ----------------------------------------------------------------------------
// llpm_node_pool
// node link and value memories, one read and one write port each
// ----------------------------------------------------------------------------
module llpm_node_pool (
	input  logic                   clk,
	input  logic                   arst_n,
	input  llpm_pkg::node_rd_t     rd,
	input  llpm_pkg::node_wr_t     wr,
	output llpm_pkg::node_rdata_t  rdata
);

	llpm_pkg::node_ptr_t nxt_mem [llpm_pkg::NODE_COUNT];
	llpm_pkg::node_ptr_t prv_mem [llpm_pkg::NODE_COUNT];
	llpm_pkg::item_t     val_mem [llpm_pkg::NODE_COUNT];

	logic [llpm_pkg::NODE_COUNT-1:0] nxt_vld_q;
	logic                            nxt_hit_q;
	llpm_pkg::node_addr_t            nxt_raddr_q;
	llpm_pkg::node_ptr_t             nxt_data_q;
	llpm_pkg::node_ptr_t             prv_data_q;
	llpm_pkg::item_t                 val_data_q;

	// memory writes and registered reads
	always_ff @(posedge clk) begin
		if (wr.nxt_we) begin
			nxt_mem[wr.nxt_addr] <= wr.nxt_data;
		end
		if (wr.prv_we) begin
			prv_mem[wr.prv_addr] <= wr.prv_data;
		end
		if (wr.val_we) begin
			val_mem[wr.val_addr] <= wr.val_data;
		end
		if (rd.nxt_en) begin
			nxt_data_q  <= nxt_mem[rd.nxt_addr];
			nxt_raddr_q <= rd.nxt_addr;
		end
		if (rd.prv_en) begin
			prv_data_q <= prv_mem[rd.prv_addr];
		end
		if (rd.val_en) begin
			val_data_q <= val_mem[rd.val_addr];
		end
	end

	// written marks for the next links, unwritten entries chain in index order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nxt_vld_q <= '0;
			nxt_hit_q <= 1'b0;
		end else begin
			if (rd.nxt_en) begin
				nxt_hit_q <= nxt_vld_q[rd.nxt_addr];
			end
			if (wr.nxt_we) begin
				nxt_vld_q[wr.nxt_addr] <= 1'b1;
			end
		end
	end

	assign rdata.nxt = nxt_hit_q ? nxt_data_q
		: llpm_pkg::node_ptr_t'(nxt_raddr_q) + llpm_pkg::node_ptr_t'(1);
	assign rdata.prv = prv_data_q;
	assign rdata.val = val_data_q;

endmodule

// ----- design/linked_list_pool_manager_unit.sv -----
// ----------------------------------------------------------------------------
// linked_list_pool_manager_unit
// sixteen doubly linked lists sharing a pool of 256 nodes
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low; its single
// result appears on status, item_out, count_out and new_list for exactly one
// cycle with done high, and must be captured then since it cannot be held
// off. A new operation may be started in the cycle that carries done. Create,
// count, concat, free, failed and status-only operations go from dispatch to
// finish; first, last and current read a value; next and prev may first
// follow a link; remove and trim unlink a node; the adding operations place
// one. The node memories serve one read and one write of each of the next,
// prev and value arrays per cycle, so link updates are spread over steps.
// Reset needs no clearing pass; the block accepts work right after reset.
module linked_list_pool_manager_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  op,
	input  logic [3:0]  list_id,
	input  logic [3:0]  other_list,
	input  logic [31:0] item,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] item_out,
	output logic [8:0]  count_out,
	output logic [3:0]  new_list
);

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_MOVE, S_VALUE, S_P1, S_P2, S_P3, S_R1, S_R2, S_FIN
	} state_t;

	localparam logic [1:0] MODE_AFTER  = 2'd0;
	localparam logic [1:0] MODE_BEFORE = 2'd1;
	localparam logic [1:0] MODE_END    = 2'd2;
	localparam logic [1:0] MODE_FRONT  = 2'd3;

	state_t state_q;

	// transaction fields
	logic [3:0]          op_q;
	llpm_pkg::list_idx_t lid_q;
	llpm_pkg::list_idx_t oid_q;
	llpm_pkg::item_t     item_q;

	// list table and its read data
	llpm_pkg::list_entry_t list_mem [llpm_pkg::LIST_COUNT];
	llpm_pkg::list_entry_t lrd_l_q;
	llpm_pkg::list_entry_t lrd_o_q;
	logic                  lwr_en;
	llpm_pkg::list_idx_t   lwr_addr;
	llpm_pkg::list_entry_t lwr_data;

	// free stacks and use flags
	llpm_pkg::node_ptr_t fnt_q;
	llpm_pkg::list_ptr_t flt_q;
	llpm_pkg::list_ptr_t fln_q [llpm_pkg::LIST_COUNT];
	logic [llpm_pkg::LIST_COUNT-1:0] in_use_q;

	// working state
	llpm_pkg::list_entry_t w_q;
	llpm_pkg::list_idx_t   wa_q;
	logic                  wen_q;
	logic [1:0]            status_q;
	llpm_pkg::item_t       res_item_q;
	llpm_pkg::list_idx_t   newl_q;
	llpm_pkg::node_ptr_t   n_q;
	llpm_pkg::node_ptr_t   at_q;
	llpm_pkg::node_ptr_t   nb_q;
	llpm_pkg::node_ptr_t   c_q;
	llpm_pkg::node_ptr_t   p_q;
	llpm_pkg::node_ptr_t   nx_q;
	logic [1:0]            mode_q;
	logic                  empty_q;

	// node pool
	llpm_pkg::node_rd_t    nrd;
	llpm_pkg::node_wr_t    nwr;
	llpm_pkg::node_rdata_t nrdata;

	// decode helpers
	llpm_pkg::node_ptr_t mv_cur;
	logic                mv_link;
	logic [1:0]          mode_eff;
	llpm_pkg::node_ptr_t at_ptr;
	llpm_pkg::node_ptr_t rm_c;
	llpm_pkg::node_ptr_t nb_sel;
	llpm_pkg::node_ptr_t move_c;
	logic                used_now;
	logic                oused_now;

	llpm_node_pool u_pool (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (nrd),
		.wr     (nwr),
		.rdata  (nrdata)
	);

	assign busy     = (state_q != S_IDLE);
	assign used_now = in_use_q[lid_q];
	assign oused_now = in_use_q[oid_q];

	// list table, read both lists when a transaction is taken
	always_ff @(posedge clk) begin
		if (lwr_en) begin
			list_mem[lwr_addr] <= lwr_data;
		end
		if (start && !busy) begin
			lrd_l_q <= list_mem[list_id];
			lrd_o_q <= list_mem[other_list];
		end
	end

	// cursor targets, insertion mode and link selects
	always_comb begin
		mv_cur  = llpm_pkg::NIL_NODE;
		mv_link = 1'b0;
		case (op_q)
			llpm_pkg::OP_FIRST:   mv_cur = lrd_l_q.head;
			llpm_pkg::OP_LAST:    mv_cur = lrd_l_q.tail;
			llpm_pkg::OP_CURRENT: mv_cur = lrd_l_q.cursor;
			llpm_pkg::OP_NEXT: begin
				mv_link = (lrd_l_q.cursor != llpm_pkg::NIL_NODE);
				if (lrd_l_q.side != llpm_pkg::SIDE_BEYOND) begin
					mv_cur = lrd_l_q.head;
				end
			end
			llpm_pkg::OP_PREV: begin
				mv_link = (lrd_l_q.cursor != llpm_pkg::NIL_NODE);
				if (lrd_l_q.side == llpm_pkg::SIDE_BEYOND) begin
					mv_cur = lrd_l_q.tail;
				end
			end
			default: mv_cur = llpm_pkg::NIL_NODE;
		endcase

		case (op_q)
			llpm_pkg::OP_ADD:    mode_eff = MODE_AFTER;
			llpm_pkg::OP_INSERT: mode_eff = MODE_BEFORE;
			llpm_pkg::OP_APPEND: mode_eff = MODE_END;
			default:             mode_eff = MODE_FRONT;
		endcase
		// null cursor falls back to an end of the list
		if (!mode_eff[1] && lrd_l_q.cursor == llpm_pkg::NIL_NODE) begin
			mode_eff = (lrd_l_q.side == llpm_pkg::SIDE_BEYOND) ? MODE_END : MODE_FRONT;
		end
		case (mode_eff)
			MODE_END:   at_ptr = lrd_l_q.tail;
			MODE_FRONT: at_ptr = lrd_l_q.head;
			default:    at_ptr = lrd_l_q.cursor;
		endcase

		rm_c   = (op_q == llpm_pkg::OP_TRIM) ? lrd_l_q.tail : lrd_l_q.cursor;
		nb_sel = mode_q[0] ? nrdata.prv : nrdata.nxt;
		move_c = (op_q == llpm_pkg::OP_NEXT) ? nrdata.nxt : nrdata.prv;
	end

	// node memory and list table requests per step
	always_comb begin
		nrd      = '0;
		nwr      = '0;
		lwr_en   = 1'b0;
		lwr_addr = wa_q;
		lwr_data = w_q;
		case (state_q)
			S_DISPATCH: begin
				if (op_q != llpm_pkg::OP_CREATE && used_now) begin
					case (op_q)
						llpm_pkg::OP_FIRST, llpm_pkg::OP_LAST, llpm_pkg::OP_CURRENT,
						llpm_pkg::OP_NEXT, llpm_pkg::OP_PREV: begin
							if (mv_link) begin
								nrd.nxt_en   = (op_q == llpm_pkg::OP_NEXT);
								nrd.nxt_addr = llpm_pkg::node_addr(lrd_l_q.cursor);
								nrd.prv_en   = (op_q == llpm_pkg::OP_PREV);
								nrd.prv_addr = llpm_pkg::node_addr(lrd_l_q.cursor);
							end else if (mv_cur != llpm_pkg::NIL_NODE) begin
								nrd.val_en   = 1'b1;
								nrd.val_addr = llpm_pkg::node_addr(mv_cur);
							end
						end
						llpm_pkg::OP_ADD, llpm_pkg::OP_INSERT, llpm_pkg::OP_APPEND,
						llpm_pkg::OP_PREPEND: begin
							if (fnt_q != llpm_pkg::NIL_NODE) begin
								nrd.nxt_en   = 1'b1;
								nrd.nxt_addr = llpm_pkg::node_addr(fnt_q);
								nrd.prv_en   = (lrd_l_q.head != llpm_pkg::NIL_NODE);
								nrd.prv_addr = llpm_pkg::node_addr(at_ptr);
							end
						end
						llpm_pkg::OP_REMOVE, llpm_pkg::OP_TRIM: begin
							if (rm_c != llpm_pkg::NIL_NODE) begin
								nrd.nxt_en   = 1'b1;
								nrd.nxt_addr = llpm_pkg::node_addr(rm_c);
								nrd.prv_en   = 1'b1;
								nrd.prv_addr = llpm_pkg::node_addr(rm_c);
								nrd.val_en   = 1'b1;
								nrd.val_addr = llpm_pkg::node_addr(rm_c);
							end
						end
						llpm_pkg::OP_CONCAT: begin
							if (oused_now && oid_q != lid_q) begin
								if (lrd_o_q.head != llpm_pkg::NIL_NODE) begin
									nwr.nxt_we   = (lrd_l_q.tail != llpm_pkg::NIL_NODE);
									nwr.nxt_addr = llpm_pkg::node_addr(lrd_l_q.tail);
									nwr.nxt_data = lrd_o_q.head;
									nwr.prv_we   = 1'b1;
									nwr.prv_addr = llpm_pkg::node_addr(lrd_o_q.head);
									nwr.prv_data = lrd_l_q.tail;
								end
								// second list is released
								lwr_en   = 1'b1;
								lwr_addr = oid_q;
								lwr_data = llpm_pkg::empty_list();
							end
						end
						llpm_pkg::OP_FREE: begin
							if (lrd_l_q.head != llpm_pkg::NIL_NODE) begin
								nwr.nxt_we   = 1'b1;
								nwr.nxt_addr = llpm_pkg::node_addr(lrd_l_q.tail);
								nwr.nxt_data = fnt_q;
							end
						end
						default: ;
					endcase
				end
			end
			S_MOVE: begin
				if (move_c != llpm_pkg::NIL_NODE) begin
					nrd.val_en   = 1'b1;
					nrd.val_addr = llpm_pkg::node_addr(move_c);
				end
			end
			S_P1: begin
				nwr.val_we   = 1'b1;
				nwr.val_addr = llpm_pkg::node_addr(n_q);
				nwr.val_data = item_q;
				nrd.nxt_en   = !mode_q[0] && !empty_q;
				nrd.nxt_addr = llpm_pkg::node_addr(at_q);
			end
			S_P2: begin
				// links of the new node
				nwr.nxt_we   = 1'b1;
				nwr.nxt_addr = llpm_pkg::node_addr(n_q);
				nwr.nxt_data = empty_q ? llpm_pkg::NIL_NODE : (mode_q[0] ? at_q : nb_sel);
				nwr.prv_we   = 1'b1;
				nwr.prv_addr = llpm_pkg::node_addr(n_q);
				nwr.prv_data = empty_q ? llpm_pkg::NIL_NODE : (mode_q[0] ? nb_sel : at_q);
			end
			S_P3: begin
				// neighbors point at the new node
				if (!empty_q) begin
					if (!mode_q[0]) begin
						nwr.nxt_we   = 1'b1;
						nwr.nxt_addr = llpm_pkg::node_addr(at_q);
						nwr.prv_we   = (nb_q != llpm_pkg::NIL_NODE);
						nwr.prv_addr = llpm_pkg::node_addr(nb_q);
					end else begin
						nwr.nxt_we   = (nb_q != llpm_pkg::NIL_NODE);
						nwr.nxt_addr = llpm_pkg::node_addr(nb_q);
						nwr.prv_we   = 1'b1;
						nwr.prv_addr = llpm_pkg::node_addr(at_q);
					end
					nwr.nxt_data = n_q;
					nwr.prv_data = n_q;
				end
			end
			S_R1: begin
				// removed node goes onto the free stack, its successor takes over its prev link
				nwr.nxt_we   = 1'b1;
				nwr.nxt_addr = llpm_pkg::node_addr(c_q);
				nwr.nxt_data = fnt_q;
				nwr.prv_we   = (nrdata.nxt != llpm_pkg::NIL_NODE);
				nwr.prv_addr = llpm_pkg::node_addr(nrdata.nxt);
				nwr.prv_data = nrdata.prv;
			end
			S_R2: begin
				nwr.nxt_we   = (p_q != llpm_pkg::NIL_NODE);
				nwr.nxt_addr = llpm_pkg::node_addr(p_q);
				nwr.nxt_data = nx_q;
			end
			S_FIN: begin
				lwr_en = wen_q;
			end
			default: ;
		endcase
	end

	// sequencer, free stacks and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			op_q       <= '0;
			lid_q      <= '0;
			oid_q      <= '0;
			item_q     <= '0;
			fnt_q      <= '0;
			flt_q      <= '0;
			for (int i = 0; i < llpm_pkg::LIST_COUNT; i++) begin
				fln_q[i] <= llpm_pkg::list_ptr_t'(i + 1);
			end
			in_use_q   <= '0;
			w_q        <= llpm_pkg::empty_list();
			wa_q       <= '0;
			wen_q      <= 1'b0;
			status_q   <= llpm_pkg::ST_OK;
			res_item_q <= '0;
			newl_q     <= '0;
			n_q        <= '0;
			at_q       <= '0;
			nb_q       <= '0;
			c_q        <= '0;
			p_q        <= '0;
			nx_q       <= '0;
			mode_q     <= MODE_AFTER;
			empty_q    <= 1'b0;
			done       <= 1'b0;
			status     <= '0;
			item_out   <= '0;
			count_out  <= '0;
			new_list   <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= op;
						lid_q   <= list_id;
						oid_q   <= other_list;
						item_q  <= item;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					w_q        <= lrd_l_q;
					wa_q       <= lid_q;
					wen_q      <= 1'b1;
					status_q   <= llpm_pkg::ST_OK;
					res_item_q <= '0;
					newl_q     <= '0;
					state_q    <= S_FIN;
					if (op_q == llpm_pkg::OP_CREATE) begin
						if (flt_q == llpm_pkg::NIL_LIST) begin
							status_q <= llpm_pkg::ST_EXHAUSTED;
							wen_q    <= 1'b0;
						end else begin
							flt_q    <= fln_q[flt_q[llpm_pkg::LIST_AW-1:0]];
							in_use_q[flt_q[llpm_pkg::LIST_AW-1:0]] <= 1'b1;
							w_q      <= llpm_pkg::empty_list();
							wa_q     <= flt_q[llpm_pkg::LIST_AW-1:0];
							newl_q   <= flt_q[llpm_pkg::LIST_AW-1:0];
						end
					end else if (!used_now) begin
						status_q <= llpm_pkg::ST_UNUSED;
						wen_q    <= 1'b0;
					end else begin
						case (op_q)
							llpm_pkg::OP_COUNT: begin
								wen_q <= 1'b0;
							end
							llpm_pkg::OP_FIRST, llpm_pkg::OP_LAST, llpm_pkg::OP_CURRENT,
							llpm_pkg::OP_NEXT, llpm_pkg::OP_PREV: begin
								if (mv_link) begin
									state_q <= S_MOVE;
								end else begin
									w_q.cursor <= mv_cur;
									if (mv_cur == llpm_pkg::NIL_NODE) begin
										status_q <= llpm_pkg::ST_NO_ITEM;
									end else begin
										w_q.side <= llpm_pkg::SIDE_ON;
										state_q  <= S_VALUE;
									end
								end
							end
							llpm_pkg::OP_ADD, llpm_pkg::OP_INSERT, llpm_pkg::OP_APPEND,
							llpm_pkg::OP_PREPEND: begin
								if (fnt_q == llpm_pkg::NIL_NODE) begin
									status_q <= llpm_pkg::ST_EXHAUSTED;
									wen_q    <= 1'b0;
								end else begin
									n_q     <= fnt_q;
									mode_q  <= mode_eff;
									at_q    <= at_ptr;
									empty_q <= (lrd_l_q.head == llpm_pkg::NIL_NODE);
									state_q <= S_P1;
								end
							end
							llpm_pkg::OP_REMOVE, llpm_pkg::OP_TRIM: begin
								w_q.cursor <= rm_c;
								if (rm_c == llpm_pkg::NIL_NODE) begin
									status_q <= llpm_pkg::ST_NO_ITEM;
								end else begin
									c_q     <= rm_c;
									state_q <= S_R1;
								end
							end
							llpm_pkg::OP_CONCAT: begin
								if (!oused_now) begin
									status_q <= llpm_pkg::ST_UNUSED;
									wen_q    <= 1'b0;
								end else if (oid_q == lid_q) begin
									wen_q <= 1'b0;
								end else begin
									if (lrd_o_q.head != llpm_pkg::NIL_NODE) begin
										if (lrd_l_q.tail == llpm_pkg::NIL_NODE) begin
											w_q.head <= lrd_o_q.head;
										end
										w_q.tail <= lrd_o_q.tail;
										w_q.len  <= llpm_pkg::count_t'(lrd_l_q.len + lrd_o_q.len);
									end
									in_use_q[oid_q] <= 1'b0;
									fln_q[oid_q]    <= flt_q;
									flt_q           <= llpm_pkg::list_ptr_t'(oid_q);
								end
							end
							llpm_pkg::OP_FREE: begin
								if (lrd_l_q.head != llpm_pkg::NIL_NODE) begin
									fnt_q <= lrd_l_q.head;
								end
								in_use_q[lid_q] <= 1'b0;
								fln_q[lid_q]    <= flt_q;
								flt_q           <= llpm_pkg::list_ptr_t'(lid_q);
								w_q             <= llpm_pkg::empty_list();
							end
							default: begin
								status_q <= llpm_pkg::ST_UNUSED;
								wen_q    <= 1'b0;
							end
						endcase
					end
				end
				S_MOVE: begin
					w_q.cursor <= move_c;
					if (move_c == llpm_pkg::NIL_NODE) begin
						w_q.side <= (op_q == llpm_pkg::OP_NEXT) ? llpm_pkg::SIDE_BEYOND
							: llpm_pkg::SIDE_BEFORE;
						status_q <= llpm_pkg::ST_NO_ITEM;
						state_q  <= S_FIN;
					end else begin
						w_q.side <= llpm_pkg::SIDE_ON;
						state_q  <= S_VALUE;
					end
				end
				S_VALUE: begin
					res_item_q <= nrdata.val;
					state_q    <= S_FIN;
				end
				S_P1: begin
					fnt_q   <= nrdata.nxt;
					state_q <= S_P2;
				end
				S_P2: begin
					nb_q <= nb_sel;
					if (empty_q) begin
						w_q.head <= n_q;
						w_q.tail <= n_q;
					end else if (nb_sel == llpm_pkg::NIL_NODE) begin
						if (mode_q[0]) begin
							w_q.head <= n_q;
						end else begin
							w_q.tail <= n_q;
						end
					end
					w_q.cursor <= n_q;
					w_q.side   <= llpm_pkg::SIDE_ON;
					w_q.len    <= w_q.len + llpm_pkg::count_t'(1);
					state_q    <= S_P3;
				end
				S_P3: begin
					state_q <= S_FIN;
				end
				S_R1: begin
					p_q        <= nrdata.prv;
					nx_q       <= nrdata.nxt;
					res_item_q <= nrdata.val;
					if (nrdata.prv == llpm_pkg::NIL_NODE) begin
						w_q.head <= nrdata.nxt;
					end
					if (nrdata.nxt == llpm_pkg::NIL_NODE) begin
						w_q.tail <= nrdata.prv;
					end
					if (nrdata.nxt != llpm_pkg::NIL_NODE) begin
						w_q.cursor <= nrdata.nxt;
					end else begin
						w_q.cursor <= nrdata.prv;
						if (nrdata.prv == llpm_pkg::NIL_NODE) begin
							w_q.side <= llpm_pkg::SIDE_BEFORE;
						end
					end
					if (w_q.len != '0) begin
						w_q.len <= w_q.len - llpm_pkg::count_t'(1);
					end
					fnt_q   <= c_q;
					state_q <= S_R2;
				end
				S_R2: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					done      <= 1'b1;
					status    <= status_q;
					item_out  <= (status_q == llpm_pkg::ST_OK) ? res_item_q : '0;
					count_out <= (op_q != llpm_pkg::OP_CREATE && status_q != llpm_pkg::ST_UNUSED)
						? w_q.len : '0;
					new_list  <= newl_q;
					state_q   <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a result only follows the finishing step
	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_FIN))
		else $error("result strobe without finishing step");

	// a taken transaction starts dispatch in the next cycle
	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> state_q == S_DISPATCH)
		else $error("accepted transaction not dispatched");

	// unused list results carry no count and no item
	a_unused_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == llpm_pkg::ST_UNUSED |-> count_out == '0 && item_out == '0)
		else $error("unused list result carries data");

	// the top of the free list stack is never a list in use
	a_free_top_unused: assert property (@(posedge clk) disable iff (!arst_n)
		flt_q != llpm_pkg::NIL_LIST |-> !in_use_q[flt_q[llpm_pkg::LIST_AW-1:0]])
		else $error("free list stack holds a list in use");

endmodule
